### design/qrs_pkg.sv
package qrs_pkg;

  // Default coefficient width and output fraction bits.
  localparam int IN_WIDTH = 16;
  localparam int OUT_FRAC = 16;

  // Width of each result value.
  localparam int OUT_WIDTH = 32;

  // Root kind codes.
  localparam logic [1:0] KIND_TWO_REAL = 2'd0;
  localparam logic [1:0] KIND_DOUBLE   = 2'd1;
  localparam logic [1:0] KIND_COMPLEX  = 2'd2;
  localparam logic [1:0] KIND_DEGEN    = 2'd3;

endpackage

### design/quadratic_root_solver_core.sv
// Channel  | Direction | Handshake                | Payload
// request  | in        | in_valid_i / in_ready_o   | coef_a_i, coef_b_i, coef_c_i
// result   | out       | out_valid_o / out_ready_i | root_kind_o, first_value_o,
//          |           |                           | second_value_o, saturated_o
//
// One request enters per cycle while the skid register is free. The pipeline has SW
// square-root stages (one root bit each) and XW divider stages (one quotient bit
// each). A skid register behind the output register lets the pipeline keep taking
// requests while one result waits. Reset clears all valid bits; payload registers
// are not reset. A stall freezes the whole pipeline.
module quadratic_root_solver_core #(
  parameter int IN_WIDTH = qrs_pkg::IN_WIDTH,
  parameter int OUT_FRAC = qrs_pkg::OUT_FRAC
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [IN_WIDTH-1:0]           coef_a_i,
  input  logic signed [IN_WIDTH-1:0]           coef_b_i,
  input  logic signed [IN_WIDTH-1:0]           coef_c_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           root_kind_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value_o,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value_o,
  output logic                                 saturated_o
);

  localparam int W    = IN_WIDTH;
  localparam int OW   = qrs_pkg::OUT_WIDTH;
  localparam int DW   = 2 * W + 1;                    // discriminant magnitude
  localparam int RW0  = DW + 2 * OUT_FRAC;
  localparam int SW   = (RW0 + 1) / 2;                // square root width
  localparam int RW   = 2 * SW;                       // padded radicand
  localparam int RQW  = SW + 3;                       // root remainder
  localparam int MBW  = W + OUT_FRAC;                 // |b| scaled
  localparam int NMW  = ((MBW > SW) ? MBW : SW) + 1;  // numerator magnitude
  localparam int NSW  = NMW + 1;                      // signed numerator
  localparam int XW   = NMW + 1;                      // dividend and quotient
  localparam int RMW  = W + 1;                        // divider remainder
  localparam int CW   = ((XW > OW) ? XW : OW) + 1;
  localparam logic [CW-1:0] MAX_POS = CW'((64'd1 << (OW - 1)) - 64'd1);
  localparam logic [CW-1:0] MIN_MAG = CW'(64'd1 << (OW - 1));

  typedef struct packed {
    logic         an;
    logic [W-1:0] am;
    logic         bn;
    logic [W-1:0] bm;
    logic         cn;
    logic [W-1:0] cm;
  } p0_t;

  typedef struct packed {
    logic           an;
    logic [W-1:0]   am;
    logic           bn;
    logic [W-1:0]   bm;
    logic           same;
    logic [2*W-1:0] b2;
    logic [DW-1:0]  t4;
  } p1_t;

  typedef struct packed {
    logic                  an;
    logic [W-1:0]          am;
    logic [1:0]            kind;
    logic signed [NSW-1:0] mb;
    logic [RW-1:0]         rad;
    logic [RQW-1:0]        rem;
    logic [SW-1:0]         root;
  } sq_t;

  typedef struct packed {
    logic                  an;
    logic [W-1:0]          am;
    logic [1:0]            kind;
    logic signed [NSW-1:0] n1;
    logic signed [NSW-1:0] n2;
  } n_t;

  typedef struct packed {
    logic [W-1:0]   am;
    logic [1:0]     kind;
    logic           neg1;
    logic           neg2;
    logic [NMW-1:0] mag1;
    logic [NMW-1:0] mag2;
  } m_t;

  typedef struct packed {
    logic [W-1:0]   am;
    logic [1:0]     kind;
    logic           neg1;
    logic           neg2;
    logic [XW-1:0]  x1;
    logic [XW-1:0]  x2;
    logic [RMW-1:0] r1;
    logic [RMW-1:0] r2;
    logic [XW-1:0]  q1;
    logic [XW-1:0]  q2;
  } dv_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [OW-1:0] v1;
    logic signed [OW-1:0] v2;
    logic                 sat;
  } res_t;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // One bit of the integer square root.
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t            r;
    logic [RQW-1:0] remn;
    logic [RQW-1:0] trial;
    r     = s;
    remn  = {s.rem[RQW-3:0], s.rad[RW-1:RW-2]};
    trial = RQW'({s.root, 2'b01});
    if (remn >= trial) begin
      r.rem  = remn - trial;
      r.root = {s.root[SW-2:0], 1'b1};
    end else begin
      r.rem  = remn;
      r.root = {s.root[SW-2:0], 1'b0};
    end
    r.rad = {s.rad[RW-3:0], 2'b00};
    return r;
  endfunction

  // One quotient bit for each of the two divisions.
  function automatic dv_t div_step(input dv_t s);
    dv_t            r;
    logic [RMW-1:0] dvs;
    logic [RMW-1:0] rn1;
    logic [RMW-1:0] rn2;
    r   = s;
    dvs = {s.am, 1'b0};
    rn1 = {s.r1[RMW-2:0], s.x1[XW-1]};
    rn2 = {s.r2[RMW-2:0], s.x2[XW-1]};
    if (rn1 >= dvs) begin
      r.r1 = rn1 - dvs;
      r.q1 = {s.q1[XW-2:0], 1'b1};
    end else begin
      r.r1 = rn1;
      r.q1 = {s.q1[XW-2:0], 1'b0};
    end
    if (rn2 >= dvs) begin
      r.r2 = rn2 - dvs;
      r.q2 = {s.q2[XW-2:0], 1'b1};
    end else begin
      r.r2 = rn2;
      r.q2 = {s.q2[XW-2:0], 1'b0};
    end
    r.x1 = {s.x1[XW-2:0], 1'b0};
    r.x2 = {s.x2[XW-2:0], 1'b0};
    return r;
  endfunction

  // Applies the sign and clips to the output range; the top bit flags clipping.
  function automatic logic [OW:0] clip(input logic neg, input logic [XW-1:0] q);
    logic [CW-1:0] qx;
    logic [CW-1:0] nq;
    qx = CW'(q);
    nq = -qx;
    if (!neg && (qx > MAX_POS)) begin
      clip = {1'b1, MAX_POS[OW-1:0]};
    end else if (neg && (qx > MIN_MAG)) begin
      clip = {1'b1, MIN_MAG[OW-1:0]};
    end else begin
      clip = {1'b0, (neg ? nq[OW-1:0] : qx[OW-1:0])};
    end
  endfunction

  logic en;
  logic out_v_q, skid_v_q;
  res_t out_q, skid_q, tail;

  logic p0_v_q, p1_v_q, n_v_q, m_v_q;
  p0_t  p0_d, p0_q;
  p1_t  p1_d, p1_q;
  sq_t  sq0_d;
  n_t   n_d, n_q;
  m_t   m_d, m_q;
  dv_t  dv0_d;

  logic sq_v_q [0:SW];
  sq_t  sq_q   [0:SW];
  logic dv_v_q [0:XW];
  dv_t  dv_q   [0:XW];

  // The pipeline moves whenever the skid register is free.
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // Split the coefficients into sign and magnitude.
  always_comb begin
    p0_d.an = coef_a_i[W-1];
    p0_d.am = mag_of(coef_a_i);
    p0_d.bn = coef_b_i[W-1];
    p0_d.bm = mag_of(coef_b_i);
    p0_d.cn = coef_c_i[W-1];
    p0_d.cm = mag_of(coef_c_i);
  end

  // Form b*b and 4*a*c.
  always_comb begin
    logic [2*W-1:0] prod;
    prod      = (2*W)'(p0_q.am) * (2*W)'(p0_q.cm);
    p1_d.an   = p0_q.an;
    p1_d.am   = p0_q.am;
    p1_d.bn   = p0_q.bn;
    p1_d.bm   = p0_q.bm;
    p1_d.same = (p0_q.an == p0_q.cn);
    p1_d.b2   = (2*W)'(p0_q.bm) * (2*W)'(p0_q.bm);
    p1_d.t4   = {prod[2*W-2:0], 2'b00};
  end

  // Discriminant magnitude, root kind and the scaled -b.
  always_comb begin
    logic [DW-1:0]         b2x;
    logic [DW-1:0]         dmag;
    logic                  dneg;
    logic [MBW-1:0]        mbm;
    logic signed [NSW-1:0] mbx;
    b2x = DW'(p1_q.b2);
    if (p1_q.same) begin
      if (b2x >= p1_q.t4) begin
        dmag = b2x - p1_q.t4;
        dneg = 1'b0;
      end else begin
        dmag = p1_q.t4 - b2x;
        dneg = 1'b1;
      end
    end else begin
      dmag = b2x + p1_q.t4;
      dneg = 1'b0;
    end
    mbm      = {p1_q.bm, {OUT_FRAC{1'b0}}};
    mbx      = $signed(NSW'(mbm));
    sq0_d.an = p1_q.an;
    sq0_d.am = p1_q.am;
    sq0_d.mb = p1_q.bn ? mbx : -mbx;
    if (p1_q.am == '0) begin
      sq0_d.kind = qrs_pkg::KIND_DEGEN;
    end else if (dmag == '0) begin
      sq0_d.kind = qrs_pkg::KIND_DOUBLE;
    end else if (dneg) begin
      sq0_d.kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      sq0_d.kind = qrs_pkg::KIND_TWO_REAL;
    end
    sq0_d.rad  = RW'({dmag, {(2*OUT_FRAC){1'b0}}});
    sq0_d.rem  = '0;
    sq0_d.root = '0;
  end

  // Numerators from -b and the square root.
  always_comb begin
    logic signed [NSW-1:0] s;
    s       = $signed(NSW'(sq_q[SW].root));
    n_d.an   = sq_q[SW].an;
    n_d.am   = sq_q[SW].am;
    n_d.kind = sq_q[SW].kind;
    if (sq_q[SW].kind == qrs_pkg::KIND_COMPLEX) begin
      n_d.n1 = sq_q[SW].mb;
      n_d.n2 = s;
    end else begin
      n_d.n1 = sq_q[SW].mb + s;
      n_d.n2 = sq_q[SW].mb - s;
    end
  end

  // Numerator magnitudes and quotient signs.
  always_comb begin
    logic [NSW-1:0] a1;
    logic [NSW-1:0] a2;
    a1        = n_q.n1[NSW-1] ? -n_q.n1 : n_q.n1;
    a2        = n_q.n2[NSW-1] ? -n_q.n2 : n_q.n2;
    m_d.am    = n_q.am;
    m_d.kind  = n_q.kind;
    m_d.neg1  = n_q.n1[NSW-1] ^ n_q.an;
    m_d.neg2  = n_q.n2[NSW-1] ^ n_q.an;
    m_d.mag1  = a1[NMW-1:0];
    m_d.mag2  = a2[NMW-1:0];
  end

  // Add |a| so that the quotient by 2|a| rounds half away from zero.
  always_comb begin
    dv0_d.am   = m_q.am;
    dv0_d.kind = m_q.kind;
    dv0_d.neg1 = m_q.neg1;
    dv0_d.neg2 = m_q.neg2;
    dv0_d.x1   = XW'(m_q.mag1) + XW'(m_q.am);
    dv0_d.x2   = XW'(m_q.mag2) + XW'(m_q.am);
    dv0_d.r1   = '0;
    dv0_d.r2   = '0;
    dv0_d.q1   = '0;
    dv0_d.q2   = '0;
  end

  // Sign, clipping and the degenerate case.
  always_comb begin
    logic [OW:0] c1;
    logic [OW:0] c2;
    c1        = clip(dv_q[XW].neg1, dv_q[XW].q1);
    c2        = clip(dv_q[XW].neg2, dv_q[XW].q2);
    tail.kind = dv_q[XW].kind;
    if (dv_q[XW].kind == qrs_pkg::KIND_DEGEN) begin
      tail.v1  = '0;
      tail.v2  = '0;
      tail.sat = 1'b0;
    end else begin
      tail.v1  = $signed(c1[OW-1:0]);
      tail.v2  = $signed(c2[OW-1:0]);
      tail.sat = c1[OW] | c2[OW];
    end
  end

  // Front stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q    <= 1'b0;
      p1_v_q    <= 1'b0;
      sq_v_q[0] <= 1'b0;
      n_v_q     <= 1'b0;
      m_v_q     <= 1'b0;
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      p0_v_q    <= in_valid_i;
      p1_v_q    <= p0_v_q;
      sq_v_q[0] <= p1_v_q;
      n_v_q     <= sq_v_q[SW];
      m_v_q     <= n_v_q;
      dv_v_q[0] <= m_v_q;
    end
  end

  // Front stage payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      sq_q[0]  <= sq0_d;
      n_q      <= n_d;
      m_q      <= m_d;
      dv_q[0]  <= dv0_d;
    end
  end

  // Square root stages.
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1] <= sqrt_step(sq_q[k]);
      end
    end
  end

  // Divider stages.
  for (genvar k = 0; k < XW; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= div_step(dv_q[k]);
      end
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (dv_v_q[XW]) begin
      if (out_v_q && !out_ready_i) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (dv_v_q[XW]) begin
      if (out_v_q && !out_ready_i) begin
        skid_q <= tail;
      end else begin
        out_q <= tail;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign root_kind_o    = out_q.kind;
  assign first_value_o  = out_q.v1;
  assign second_value_o = out_q.v2;
  assign saturated_o    = out_q.sat;

  // The skid register only fills behind a waiting result.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result with the output register empty");

  // A degenerate request gives zero values and no clipping.
  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.kind == qrs_pkg::KIND_DEGEN)) |->
      ((out_q.v1 == '0) && (out_q.v2 == '0) && !out_q.sat))
    else $error("degenerate result with nonzero values");

  // A double root reports the same value twice.
  a_double_same : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.kind == qrs_pkg::KIND_DOUBLE)) |-> (out_q.v1 == out_q.v2))
    else $error("double root with differing values");

endmodule

### dv/qrs_checker.sv
`timescale 1ns / 1ps

module qrs_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [15:0]                   coef_a_i,
  input  logic signed [15:0]                   coef_b_i,
  input  logic signed [15:0]                   coef_c_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [1:0]                           root_kind_i,
  input  logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value_i,
  input  logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value_i,
  input  logic                                 saturated_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   solved_count_o,
  output int                                   kind_seen_o [4],
  output int                                   clip_count_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] first;
    logic [31:0] second;
    logic        sat;
  } roots_t;

  roots_t expected_roots_q[$];

  // Integer square root floor of a 96-bit value, one bit per step.
  function automatic logic [63:0] isqrt96(input logic [95:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      c = r | (64'd1 << k);
      sq = c * c;
      if (sq <= {32'd0, x}) r = c;
    end
    return r;
  endfunction

  // Rounded quotient num / (2a), ties away from zero, clipped to 32 bits.
  function automatic logic [31:0] div_round(input logic signed [63:0] num,
                                            input logic signed [31:0] a,
                                            inout logic sat);
    logic [63:0] n_mag;
    logic [63:0] a_mag;
    logic [63:0] q;
    logic        neg;
    n_mag = num < 0 ? -num : num;
    a_mag = a < 0 ? -a : a;
    q = (n_mag + a_mag) / (2 * a_mag);
    neg = (num < 0) != (a < 0);
    if (!neg && q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (neg && q > 64'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return neg ? 32'(-q) : 32'(q);
  endfunction

  // Work out the roots of one coefficient set.
  function automatic roots_t solve_roots(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic signed [15:0] c);
    roots_t              r;
    logic signed [47:0]  disc;
    logic [47:0]         d_mag;
    logic [63:0]         s;
    logic signed [63:0]  mb;
    logic                sat;
    sat = 1'b0;
    r = '0;
    if (a == 0) begin
      r.kind = qrs_pkg::KIND_DEGEN;
      return r;
    end
    disc = 48'(b) * 48'(b) - 48'sd4 * 48'(a) * 48'(c);
    d_mag = disc < 0 ? -disc : disc;
    s = isqrt96({d_mag, 48'd0} >> (48 - 2 * qrs_pkg::OUT_FRAC));
    mb = -(64'(b) <<< qrs_pkg::OUT_FRAC);
    if (disc == 0) begin
      r.kind = qrs_pkg::KIND_DOUBLE;
      r.first = div_round(mb, 32'(a), sat);
      r.second = r.first;
    end else if (disc > 0) begin
      r.kind = qrs_pkg::KIND_TWO_REAL;
      r.first = div_round(mb + $signed(s), 32'(a), sat);
      r.second = div_round(mb - $signed(s), 32'(a), sat);
    end else begin
      r.kind = qrs_pkg::KIND_COMPLEX;
      r.first = div_round(mb, 32'(a), sat);
      r.second = div_round($signed(s), 32'(a), sat);
    end
    r.sat = sat;
    return r;
  endfunction

  assign pending_o = expected_roots_q.size();

  // Predict on each accepted request and compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    roots_t exp_r;
    if (!rst_ni) begin
      expected_roots_q.delete();
      fail_count_o <= 0;
      solved_count_o <= 0;
      clip_count_o <= 0;
      for (int i = 0; i < 4; i++) kind_seen_o[i] <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_roots_q.push_back(solve_roots(coef_a_i, coef_b_i, coef_c_i));
      if (out_valid_i && out_ready_i) begin
        solved_count_o <= solved_count_o + 1;
        kind_seen_o[root_kind_i] <= kind_seen_o[root_kind_i] + 1;
        if (saturated_i) clip_count_o <= clip_count_o + 1;
        if (expected_roots_q.size() == 0) begin
          $display("%0t: result with no request pending: kind %0d %h %h sat %b", $time,
                   root_kind_i, first_value_i, second_value_i, saturated_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_roots_q.pop_front();
          if (exp_r.kind !== root_kind_i || exp_r.first !== first_value_i ||
              exp_r.second !== second_value_i || exp_r.sat !== saturated_i) begin
            $display("%0t: mismatch expected kind %0d %h %h sat %b, got kind %0d %h %h sat %b",
                     $time, exp_r.kind, exp_r.first, exp_r.second, exp_r.sat,
                     root_kind_i, first_value_i, second_value_i, saturated_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = 75;
  localparam int STALL_LIMIT = 4000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic signed [15:0]  coef_a_i;
  logic signed [15:0]  coef_b_i;
  logic signed [15:0]  coef_c_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          root_kind_o;
  logic signed [31:0]  first_value_o;
  logic signed [31:0]  second_value_o;
  logic                saturated_o;
  int                  fail_count;
  int                  pending;
  int                  solved_count;
  int                  kind_seen [4];
  int                  clip_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  idle_cycles;

  quadratic_root_solver_core dut (.*);

  qrs_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .coef_a_i, .coef_b_i, .coef_c_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .root_kind_i(root_kind_o), .first_value_i(first_value_o),
    .second_value_i(second_value_o), .saturated_i(saturated_o),
    .fail_count_o(fail_count), .pending_o(pending), .solved_count_o(solved_count),
    .kind_seen_o(kind_seen), .clip_count_o(clip_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls at random at the current rate.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("** quadratic_root_solver_core: FAILED **");
      $finish;
    end
  end

  // Send one request and hold it until accepted; valid drops only while idling.
  task automatic send_request(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Random coefficients: mostly small magnitudes, some full range.
  function automatic logic [15:0] rand_coef();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(512)) - 256);
      2: return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($urandom_range(1) ? 16'h0100 : 16'hFF00) *
                     16'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    int          r;
    for (int i = 0; i < n; i++) begin
      a = rand_coef();
      b = rand_coef();
      c = rand_coef();
      r = $urandom_range(9);
      // Steer toward double roots and leading-zero cases now and then.
      if (r == 0) a = '0;
      else if (r == 1) begin
        a = 16'h0100;
        c = 16'($signed($urandom_range(64)) * 16'sd256);
        b = 16'($urandom_range(1) ? 16'h0200 : 16'hFE00) * 16'($sqrt(real'(c) / 256.0));
      end
      send_request(a, b, c);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b1;
    coef_a_i = '0;
    coef_b_i = '0;
    coef_c_i = '0;
    send_idle_pct = 31;
    recv_idle_pct = 49;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, each kind, leading zero and clipping.
    send_request(16'h0000, 16'h1234, 16'h5678);
    send_request(16'h0000, 16'h8000, 16'h7FFF);
    send_request(16'h0100, 16'hFD00, 16'h0200);
    send_request(16'h0100, 16'hFE00, 16'h0100);
    send_request(16'h0100, 16'h0000, 16'h0100);
    send_request(16'hFF00, 16'h0000, 16'hFF00);
    send_request(16'h0001, 16'h7FFF, 16'h0000);
    send_request(16'h0001, 16'h8000, 16'h8000);
    send_request(16'h8000, 16'h8000, 16'h8000);
    send_request(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_request(16'h8000, 16'h7FFF, 16'h7FFF);
    send_request(16'h7FFF, 16'h8000, 16'h8000);
    send_request(16'hFFFF, 16'h0000, 16'h7FFF);
    send_request(16'h0001, 16'h0000, 16'h7FFF);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(16'h5555, 16'hAAAA, 16'h5555);
    send_request(16'hAAAA, 16'h5555, 16'hAAAA);
    send_request(16'h0100, 16'h0000, 16'h0000);

    random_phase(310);
    send_idle_pct = 49;
    recv_idle_pct = 31;
    random_phase(310);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(310);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Solved %0d sets: %0d two real, %0d double, %0d complex, %0d degenerate.",
             solved_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("%0d results clipped, %0d mismatches.", clip_count, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("** quadratic_root_solver_core: PASSED **");
    else
      $display("** quadratic_root_solver_core: FAILED **");
    $finish;
  end

endmodule
